FILE: rtl/lots_pkg.sv
// shared constants and types of the letter order sort
package lots_pkg;
	localparam int MAX_WORD_LEN_D = 128;
	localparam int ALPHABET_D = 26;
	localparam int LW = 5;
	localparam int PW = 8;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_PREFIX = 2'd1,
		ST_CYCLE  = 2'd2,
		ST_LONG   = 2'd3
	} status_t;

	typedef struct packed {
		logic          clear;
		logic          mark;
		logic          add;
		logic          step;
		logic [LW-1:0] src;
		logic [LW-1:0] dst;
	} graph_cmd_t;

	typedef struct packed {
		logic          found;
		logic [LW-1:0] pick;
		logic          complete;
		logic          any;
	} graph_stat_t;
endpackage

FILE: rtl/lots_if.sv
// letter input and order output channel interfaces
interface lots_in_if;
	logic                   valid;
	logic                   ready;
	logic [lots_pkg::LW-1:0] letter;
	logic                   word_end;
	logic                   list_end;
	modport source (output valid, letter, word_end, list_end, input ready);
	modport sink (input valid, letter, word_end, list_end, output ready);
endinterface

interface lots_out_if;
	logic                   valid;
	logic                   ready;
	logic [lots_pkg::LW-1:0] out_letter;
	logic [1:0]             status;
	logic                   last;
	modport source (output valid, out_letter, status, last, input ready);
	modport sink (input valid, out_letter, status, last, output ready);
endinterface

FILE: rtl/lots_ram.sv
// generic single-port-write ram with registered read
module lots_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd,
	input  logic [AW-1:0]    ra,
	output logic [WIDTH-1:0] rd
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end
endmodule

FILE: rtl/lots_graph.sv
// edge matrix, in-degree counters and kahn pick logic
module lots_graph #(
	parameter int ALPHABET = lots_pkg::ALPHABET_D
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lots_pkg::graph_cmd_t  cmd,
	output lots_pkg::graph_stat_t stat
);
	import lots_pkg::*;

	localparam int IW = $clog2(ALPHABET);

	logic [ALPHABET-1:0] edge_q [ALPHABET];
	logic [LW-1:0]       deg_q [ALPHABET];
	logic [ALPHABET-1:0] present_q;
	logic [ALPHABET-1:0] emitted_q;
	logic [ALPHABET-1:0] rdy;
	logic [IW-1:0]       pick_i;
	logic [IW-1:0]       src_i;
	logic [IW-1:0]       dst_i;

	assign src_i = cmd.src[IW-1:0];
	assign dst_i = cmd.dst[IW-1:0];

	always_comb begin
		pick_i = '0;
		for (int i = ALPHABET - 1; i >= 0; i--) begin
			rdy[i] = present_q[i] & ~emitted_q[i] & (deg_q[i] == '0);
			if (rdy[i]) begin
				pick_i = IW'(i);
			end
		end
	end

	assign stat.found    = |rdy;
	assign stat.pick     = LW'(pick_i);
	assign stat.complete = (present_q == emitted_q);
	assign stat.any      = |present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			emitted_q <= '0;
			for (int i = 0; i < ALPHABET; i++) begin
				edge_q[i] <= '0;
				deg_q[i]  <= '0;
			end
		end else if (cmd.clear) begin
			present_q <= '0;
			emitted_q <= '0;
			for (int i = 0; i < ALPHABET; i++) begin
				edge_q[i] <= '0;
				deg_q[i]  <= '0;
			end
		end else begin
			if (cmd.mark) begin
				present_q[dst_i] <= 1'b1;
			end
			if (cmd.add && !edge_q[src_i][dst_i]) begin
				edge_q[src_i][dst_i] <= 1'b1;
				deg_q[dst_i]         <= deg_q[dst_i] + 1'b1;
			end
			if (cmd.step) begin
				emitted_q[pick_i] <= 1'b1;
				for (int j = 0; j < ALPHABET; j++) begin
					if (edge_q[pick_i][j] && deg_q[j] != '0) begin
						deg_q[j] <= deg_q[j] - 1'b1;
					end
				end
			end
		end
	end
endmodule

FILE: rtl/letter_order_topo_sort.sv
// letter order derivation: top level with build control, sort sequencer and output register
// build: each letter transaction passes through S_IDLE (previous-word memory read), then S_PROC (compare and write)
// list end: S_END settles, then S_SORT picks one letter at a time and finishes when no letter is ready
// output: one result transaction per cycle while the sink is ready, last flag on the final one
// arst_n clears all list state, edge matrix and degrees at once; previous-word memory is not cleared
module letter_order_topo_sort #(
	parameter int MAX_WORD_LEN = lots_pkg::MAX_WORD_LEN_D,
	parameter int ALPHABET = lots_pkg::ALPHABET_D
) (
	input  logic       clk,
	input  logic       arst_n,
	lots_in_if.sink    letters_ch,
	lots_out_if.source order_ch
);
	import lots_pkg::*;

	localparam int AW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int IW = $clog2(ALPHABET);
	localparam int CW = $clog2(ALPHABET + 1);

	typedef enum logic [2:0] {S_IDLE, S_PROC, S_END, S_SORT, S_OUT, S_ERR} state_t;

	state_t        state_q;
	logic [LW-1:0] letter_s1;
	logic          wend_s1;
	logic          lend_s1;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] plen_q;
	logic          peq_q;
	logic          first_q;
	status_t       err_q;
	logic [LW-1:0] order_q [ALPHABET];
	logic [CW-1:0] n_q;
	logic [CW-1:0] k_q;
	logic          ovalid_q;
	logic [LW-1:0] oletter_q;
	status_t       ostatus_q;
	logic          olast_q;

	logic [LW-1:0] prev_rd;
	logic          ram_we;
	graph_cmd_t    gcmd;
	graph_stat_t   gstat;
	logic          slot_free;

	// build step variables
	logic          take;
	logic          room;
	logic          cmp;
	logic [PW-1:0] pos_n;
	logic          peq_n;
	status_t       err_n;

	assign slot_free        = !ovalid_q || order_ch.ready;
	assign letters_ch.ready = (state_q == S_IDLE);
	assign order_ch.valid      = ovalid_q;
	assign order_ch.out_letter = oletter_q;
	assign order_ch.status     = ostatus_q;
	assign order_ch.last       = olast_q;

	always_comb begin
		take  = (state_q == S_PROC) && (err_q == ST_OK) && (letter_s1 < LW'(ALPHABET));
		room  = pos_q < PW'(MAX_WORD_LEN);
		cmp   = !first_q && peq_q && (pos_q < plen_q);
		pos_n = pos_q;
		peq_n = peq_q;
		err_n = err_q;
		gcmd  = '0;
		gcmd.src = prev_rd;
		gcmd.dst = letter_s1;
		ram_we = 1'b0;
		if (take) begin
			if (!room) begin
				err_n = ST_LONG;
			end else begin
				gcmd.mark = 1'b1;
				ram_we    = 1'b1;
				pos_n     = pos_q + 1'b1;
				if (cmp && prev_rd != letter_s1) begin
					peq_n    = 1'b0;
					gcmd.add = (prev_rd < LW'(ALPHABET));
				end
			end
		end
		if (state_q == S_SORT) begin
			gcmd.step = gstat.found;
		end
		if ((state_q == S_END && err_q == ST_OK && !gstat.any)
				|| (state_q == S_OUT && slot_free && k_q == n_q - 1'b1)
				|| (state_q == S_ERR && slot_free)) begin
			gcmd.clear = 1'b1;
		end
	end

	lots_ram #(.WIDTH(LW), .DEPTH(MAX_WORD_LEN), .AW(AW)) u_prev (
		.clk (clk),
		.we  (ram_we),
		.wa  (pos_q[AW-1:0]),
		.wd  (letter_s1),
		.ra  (pos_q[AW-1:0]),
		.rd  (prev_rd)
	);

	lots_graph #(.ALPHABET(ALPHABET)) u_graph (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (gcmd),
		.stat   (gstat)
	);

	always_ff @(posedge clk) begin
		if (letters_ch.valid && letters_ch.ready) begin
			letter_s1 <= letters_ch.letter;
			wend_s1   <= letters_ch.word_end;
			lend_s1   <= letters_ch.list_end;
		end
		if (state_q == S_SORT && gstat.found) begin
			order_q[n_q[IW-1:0]] <= gstat.pick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pos_q     <= '0;
			plen_q    <= '0;
			peq_q     <= 1'b1;
			first_q   <= 1'b1;
			err_q     <= ST_OK;
			n_q       <= '0;
			k_q       <= '0;
			ovalid_q  <= 1'b0;
			oletter_q <= '0;
			ostatus_q <= ST_OK;
			olast_q   <= 1'b0;
		end else begin
			if (order_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (letters_ch.valid) begin
						state_q <= S_PROC;
					end
				end
				S_PROC: begin
					pos_q <= pos_n;
					peq_q <= peq_n;
					err_q <= err_n;
					if ((wend_s1 || lend_s1) && pos_n != '0) begin
						if (err_n == ST_OK && !first_q && peq_n && pos_n < plen_q) begin
							err_q <= ST_PREFIX;
						end
						plen_q  <= pos_n;
						pos_q   <= '0;
						peq_q   <= 1'b1;
						first_q <= 1'b0;
					end
					state_q <= lend_s1 ? S_END : S_IDLE;
				end
				S_END: begin
					n_q <= '0;
					k_q <= '0;
					if (err_q != ST_OK) begin
						state_q <= S_ERR;
					end else if (gstat.any) begin
						state_q <= S_SORT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SORT: begin
					if (gstat.found) begin
						n_q <= n_q + 1'b1;
					end else if (gstat.complete) begin
						state_q <= S_OUT;
					end else begin
						err_q   <= ST_CYCLE;
						state_q <= S_ERR;
					end
				end
				S_OUT: begin
					if (slot_free) begin
						ovalid_q  <= 1'b1;
						oletter_q <= order_q[k_q[IW-1:0]];
						ostatus_q <= ST_OK;
						olast_q   <= (k_q == n_q - 1'b1);
						k_q       <= k_q + 1'b1;
						if (k_q == n_q - 1'b1) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ERR: begin
					if (slot_free) begin
						ovalid_q  <= 1'b1;
						oletter_q <= '0;
						ostatus_q <= err_q;
						olast_q   <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// list state returns to reset once the list is done
			if (gcmd.clear) begin
				pos_q   <= '0;
				plen_q  <= '0;
				peq_q   <= 1'b1;
				first_q <= 1'b1;
				err_q   <= ST_OK;
			end
		end
	end
endmodule

FILE: rtl/lots_check.sv
// port-level checks on the order output channel
module lots_check (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    o_valid,
	input logic                    o_ready,
	input logic [lots_pkg::LW-1:0] o_letter,
	input logic [1:0]              o_status,
	input logic                    o_last
);
	import lots_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid && $stable(o_letter) && $stable(o_status)
			&& $stable(o_last))
		else $error("output transaction dropped or changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_status != ST_OK |-> o_last)
		else $error("error transaction not marked last");

	a_err_letter: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_status != ST_OK |-> o_letter == '0)
		else $error("error transaction carries a letter");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid |-> o_letter < LW'(ALPHABET_D))
		else $error("output letter out of range");
endmodule

bind letter_order_topo_sort lots_check u_lots_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.o_valid  (order_ch.valid),
	.o_ready  (order_ch.ready),
	.o_letter (order_ch.out_letter),
	.o_status (order_ch.status),
	.o_last   (order_ch.last)
);
